FILE: design/mrte_pkg.sv
`default_nettype none
package mrte_pkg;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_ADDU = 5'd1, OP_SUB = 5'd2, OP_SUBU = 5'd3,
		OP_AND = 5'd4, OP_OR = 5'd5, OP_XOR = 5'd6, OP_MULT = 5'd7,
		OP_MULTU = 5'd8, OP_DIV = 5'd9, OP_DIVU = 5'd10, OP_MFHI = 5'd11,
		OP_MFLO = 5'd12, OP_MTHI = 5'd13, OP_MTLO = 5'd14, OP_SLT = 5'd15,
		OP_SLTU = 5'd16, OP_SLL = 5'd17, OP_SLLV = 5'd18, OP_SRL = 5'd19,
		OP_SRLV = 5'd20, OP_SRA = 5'd21, OP_SRAV = 5'd22, OP_JR = 5'd23,
		OP_JALR = 5'd24
	} op_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned IN_W = 5 + 32 + 32 + 5 + 5 + 32;
	localparam int unsigned IN_BYTES_W = 112;
	localparam int unsigned OUT_W = 1 + 5 + 32 + 2 + 1 + 32;
	localparam int unsigned OUT_BYTES_W = 80;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [4:0] LINK_REG = 5'd31;
	localparam logic [31:0] LINK_OFFSET = 32'd8;

	// Work classes sorted out by the front end.
	typedef enum logic [1:0] {
		CL_SIMPLE = 2'd0,
		CL_MUL = 2'd1,
		CL_DIV = 2'd2,
		CL_HILO = 2'd3
	} cls_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_MUL, BK_DIV, BK_DFIX, BK_OUT
	} bk_state_t;

	typedef struct packed {
		cls_t        cls;
		op_t         op;
		logic        sgn;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] res;
		logic        we;
		logic [4:0]  wreg;
		logic [1:0]  status;
		logic        jt;
	} job_t;

	typedef struct packed {
		logic        we;
		logic [4:0]  wreg;
		logic [31:0] wval;
		logic [1:0]  status;
		logic        jt;
		logic [31:0] jtarget;
	} res_t;

endpackage
`default_nettype wire

FILE: design/mips_r_type_execute_unit_core.sv
// R-type execute unit with HI/LO multiply and divide.
// Input channel s_axis_*: one decoded instruction per transaction.
// Output channel m_axis_*: exactly one result transaction per instruction,
// in order. The front end classifies, computes all but multiply, divide and
// HI/LO moves, queues up to two instructions; the back end runs one at a time.
// An instruction passes through the queue, then the back end states: simple
// ops and moves go straight to output, multiply computes HI/LO first, and
// divide makes 32 quotient bits, one per cycle, then a sign fix step. The
// back end takes a new instruction only after the last result is accepted.
// Traps (overflow, zero divisor) write no register and leave HI/LO alone.
// Reset clears HI, LO, the queue and the back end control.
// When the receiver holds m_axis_tready low the result waits; the queue
// keeps accepting until full, then s_axis_tready drops.
`default_nettype none
module mips_r_type_execute_unit_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// action, source_a, source_b, dest_reg, shift_amount, pc_value, zero pad
	input  wire logic [mrte_pkg::IN_BYTES_W-1:0]  s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// write_enable, write_reg, write_value, status, jump_taken, jump_target, pad
	output logic [mrte_pkg::OUT_BYTES_W-1:0]  m_axis_tdata
);
	import mrte_pkg::*;

	logic job_valid, job_ready;
	job_t job;
	res_t res;

	mrte_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.action(s_axis_tdata[4:0]), .source_a(s_axis_tdata[36:5]),
		.source_b(s_axis_tdata[68:37]), .dest_reg(s_axis_tdata[73:69]),
		.shift_amount(s_axis_tdata[78:74]), .pc_value(s_axis_tdata[110:79]),
		.job_valid, .job_ready, .job
	);

	mrte_back u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {7'd0, res.jtarget, res.jt, res.status, res.wval,
		res.wreg, res.we};

endmodule
`default_nettype wire

FILE: design/mrte_front.sv
`default_nettype none
module mrte_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [4:0]      action,
	input  wire logic [31:0]     source_a,
	input  wire logic [31:0]     source_b,
	input  wire logic [4:0]      dest_reg,
	input  wire logic [4:0]      shift_amount,
	input  wire logic [31:0]     pc_value,
	output logic                 job_valid,
	input  wire logic            job_ready,
	output mrte_pkg::job_t       job
);
	import mrte_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	job_t                 cls_job;
	job_t                 mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_q, rd_q;
	logic [PTR_W:0]       cnt_q;
	logic [4:0]           samt;
	logic [31:0]          sum, dif;
	logic                 push, pop;

	assign in_ready  = (cnt_q != QUEUE_DEPTH[PTR_W:0]);
	assign job_valid = (cnt_q != '0);
	assign job       = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;

	assign sum = source_a + source_b;
	assign dif = source_a - source_b;

	// Everything but multiply, divide and the HI/LO moves is finished here in one step.
	always_comb begin
		samt = shift_amount;
		cls_job = '0;
		cls_job.op = op_t'(action);
		cls_job.a = source_a;
		cls_job.b = source_b;
		cls_job.wreg = dest_reg;
		cls_job.cls = CL_SIMPLE;
		if (action == OP_SLLV || action == OP_SRLV || action == OP_SRAV)
			samt = source_a[4:0];
		unique case (action)
			OP_ADD: begin
				if ((~(source_a[31] ^ source_b[31])) & (source_a[31] ^ sum[31]))
					cls_job.status = ST_OVF;
				else begin
					cls_job.we = 1'b1;
					cls_job.res = sum;
				end
			end
			OP_ADDU: begin cls_job.we = 1'b1; cls_job.res = sum; end
			OP_SUB: begin
				if ((source_a[31] ^ source_b[31]) & (source_a[31] ^ dif[31]))
					cls_job.status = ST_OVF;
				else begin
					cls_job.we = 1'b1;
					cls_job.res = dif;
				end
			end
			OP_SUBU: begin cls_job.we = 1'b1; cls_job.res = dif; end
			OP_AND: begin cls_job.we = 1'b1; cls_job.res = source_a & source_b; end
			OP_OR: begin cls_job.we = 1'b1; cls_job.res = source_a | source_b; end
			OP_XOR: begin cls_job.we = 1'b1; cls_job.res = source_a ^ source_b; end
			OP_MULT, OP_MULTU: begin
				cls_job.cls = CL_MUL;
				cls_job.sgn = (action == OP_MULT);
			end
			OP_DIV, OP_DIVU: begin
				if (source_b == '0)
					cls_job.status = ST_DIVZ;
				else begin
					cls_job.cls = CL_DIV;
					cls_job.sgn = (action == OP_DIV);
				end
			end
			OP_MFHI, OP_MFLO, OP_MTHI, OP_MTLO: begin
				cls_job.cls = CL_HILO;
				cls_job.we = (action == OP_MFHI || action == OP_MFLO);
			end
			OP_SLT: begin
				cls_job.we = 1'b1;
				cls_job.res = {31'd0, $signed(source_a) < $signed(source_b)};
			end
			OP_SLTU: begin
				cls_job.we = 1'b1;
				cls_job.res = {31'd0, source_a < source_b};
			end
			OP_SLL, OP_SLLV: begin cls_job.we = 1'b1; cls_job.res = source_b << samt; end
			OP_SRL, OP_SRLV: begin cls_job.we = 1'b1; cls_job.res = source_b >> samt; end
			OP_SRA, OP_SRAV: begin
				cls_job.we = 1'b1;
				cls_job.res = $unsigned($signed(source_b) >>> samt);
			end
			OP_JR: cls_job.jt = 1'b1;
			OP_JALR: begin
				cls_job.jt = 1'b1;
				cls_job.we = 1'b1;
				cls_job.wreg = LINK_REG;
				cls_job.res = pc_value + LINK_OFFSET;
			end
			default: cls_job.wreg = '0;
		endcase
		if (!cls_job.we)
			cls_job.wreg = '0;
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= cls_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: design/mrte_back.sv
`default_nettype none
module mrte_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            job_valid,
	output logic                 job_ready,
	input  wire mrte_pkg::job_t  job,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output mrte_pkg::res_t       res
);
	import mrte_pkg::*;

	bk_state_t    state_q, state_d;
	job_t         job_q;
	logic [31:0]  hi_q, lo_q;
	logic [31:0]  rem_q, quo_q, dvs_q;
	logic [5:0]   cnt_q;
	logic         nega_q, negq_q;
	logic [33:0]  trial;
	logic [32:0]  rem_sh;
	logic signed [65:0] prod;
	logic         take;

	assign take = job_valid && job_ready;
	// One 33-bit signed multiplier serves both signed and unsigned forms.
	assign prod = $signed({job_q.sgn & job_q.a[31], job_q.a})
	            * $signed({job_q.sgn & job_q.b[31], job_q.b});
	assign rem_sh = {rem_q, quo_q[31]};
	assign trial = {1'b0, rem_sh} - {2'b0, dvs_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (job_valid) begin
				if (job.cls == CL_MUL) state_d = BK_MUL;
				else if (job.cls == CL_DIV) state_d = BK_DIV;
				else state_d = BK_OUT;
			end
			BK_MUL: state_d = BK_OUT;
			BK_DIV: if (cnt_q == 6'd31) state_d = BK_DFIX;
			BK_DFIX: state_d = BK_OUT;
			BK_OUT: if (res_ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (state_q == BK_IDLE);
		res_valid = (state_q == BK_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			hi_q <= '0;
			lo_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_MUL) begin
				hi_q <= prod[63:32];
				lo_q <= prod[31:0];
			end
			if (state_q == BK_DFIX) begin
				lo_q <= negq_q ? 32'd0 - quo_q : quo_q;
				hi_q <= nega_q ? 32'd0 - rem_q : rem_q;
			end
			if (state_q == BK_OUT && res_ready && job_q.cls == CL_HILO) begin
				if (job_q.op == OP_MTHI) hi_q <= job_q.a;
				if (job_q.op == OP_MTLO) lo_q <= job_q.a;
			end
		end
	end

	// Job capture and restoring divider: one quotient bit per cycle on magnitudes.
	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= job;
			cnt_q <= '0;
			rem_q <= '0;
			nega_q <= job.sgn & job.a[31];
			negq_q <= job.sgn & (job.a[31] ^ job.b[31]);
			quo_q <= (job.sgn && job.a[31]) ? 32'd0 - job.a : job.a;
			dvs_q <= (job.sgn && job.b[31]) ? 32'd0 - job.b : job.b;
		end else if (state_q == BK_DIV) begin
			cnt_q <= cnt_q + 6'd1;
			if (!trial[33]) rem_q <= trial[31:0];
			else rem_q <= rem_sh[31:0];
			quo_q <= {quo_q[30:0], ~trial[33]};
		end
	end

	always_comb begin
		res = '0;
		res.we = job_q.we;
		res.wreg = job_q.wreg;
		res.status = job_q.status;
		res.jt = job_q.jt;
		res.jtarget = job_q.jt ? job_q.a : 32'd0;
		if (job_q.we) begin
			if (job_q.cls == CL_HILO)
				res.wval = (job_q.op == OP_MFHI) ? hi_q : lo_q;
			else
				res.wval = job_q.res;
		end
	end

endmodule
`default_nettype wire

FILE: design/mrte_checker.sv
`default_nettype none
module mrte_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [79:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_trap_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[39:38] != 2'd0 |-> !m_axis_tdata[0])
		else $error("trap with register write");
	a_jt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[40] |-> m_axis_tdata[72:41] == 32'd0)
		else $error("jump target without jump");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:38] != 2'd3)
		else $error("bad status");
endmodule

bind mips_r_type_execute_unit_core mrte_checker u_chk (.*);
`default_nettype wire

FILE: dv/mips_r_type_execute_unit_core_tb.sv
`default_nettype none
module mips_r_type_execute_unit_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mrte_pkg::*;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// action, source_a, source_b, dest_reg, shift_amount, pc_value, zero pad
	logic [IN_BYTES_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// write_enable, write_reg, write_value, status, jump_taken, jump_target, pad
	logic [OUT_BYTES_W-1:0] m_axis_tdata;

	mips_r_type_execute_unit_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	typedef struct {
		logic [4:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic [4:0]  rd;
		logic [4:0]  sh;
		logic [31:0] pc;
		bit          typed;
		res_t        res;
	} instr_row_t;

	logic [31:0] hi_reg, lo_reg;
	res_t        result_q[$];
	int          errors;
	int          gap_pct, stall_pct;
	int          hold_cycles;
	bit          row_typed;
	res_t        row_res;
	int unsigned accepted;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("mips_r_type_execute_unit_core regression: fail");
		$finish;
	end

	// Computes the result of one instruction and updates HI/LO.
	task automatic execute_instr(input logic [111:0] d, output res_t r);
		logic [4:0]  op;
		logic [31:0] a, b, pc, ua, ub, q, rm, v, sum;
		logic [4:0]  rd, sh;
		logic [63:0] p;
		bit          wr;
		op = d[4:0];
		a = d[36:5];
		b = d[68:37];
		rd = d[73:69];
		sh = d[78:74];
		pc = d[110:79];
		r = '0;
		wr = 0;
		v = '0;
		case (op)
			OP_ADD: begin
				sum = a + b;
				if ((~(a ^ b) & (a ^ sum)) & 32'h8000_0000) r.status = ST_OVF;
				else begin v = sum; wr = 1; end
			end
			OP_ADDU: begin v = a + b; wr = 1; end
			OP_SUB: begin
				sum = a - b;
				if (((a ^ b) & (a ^ sum)) & 32'h8000_0000) r.status = ST_OVF;
				else begin v = sum; wr = 1; end
			end
			OP_SUBU: begin v = a - b; wr = 1; end
			OP_AND: begin v = a & b; wr = 1; end
			OP_OR: begin v = a | b; wr = 1; end
			OP_XOR: begin v = a ^ b; wr = 1; end
			OP_MULT: begin
				p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
				{hi_reg, lo_reg} = p;
			end
			OP_MULTU: begin
				p = {32'd0, a} * {32'd0, b};
				{hi_reg, lo_reg} = p;
			end
			OP_DIV: begin
				if (b == 0) r.status = ST_DIVZ;
				else begin
					ua = a[31] ? -a : a;
					ub = b[31] ? -b : b;
					q = ua / ub;
					rm = ua % ub;
					if (a[31] != b[31]) q = -q;
					if (a[31]) rm = -rm;
					lo_reg = q;
					hi_reg = rm;
				end
			end
			OP_DIVU: begin
				if (b == 0) r.status = ST_DIVZ;
				else begin lo_reg = a / b; hi_reg = a % b; end
			end
			OP_MFHI: begin v = hi_reg; wr = 1; end
			OP_MFLO: begin v = lo_reg; wr = 1; end
			OP_MTHI: hi_reg = a;
			OP_MTLO: lo_reg = a;
			OP_SLT: begin v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; wr = 1; end
			OP_SLTU: begin v = (a < b) ? 32'd1 : 32'd0; wr = 1; end
			OP_SLL: begin v = b << sh; wr = 1; end
			OP_SLLV: begin v = b << a[4:0]; wr = 1; end
			OP_SRL: begin v = b >> sh; wr = 1; end
			OP_SRLV: begin v = b >> a[4:0]; wr = 1; end
			OP_SRA: begin v = $signed(b) >>> sh; wr = 1; end
			OP_SRAV: begin v = $signed(b) >>> a[4:0]; wr = 1; end
			OP_JR: begin r.jt = 1; r.jtarget = a; end
			OP_JALR: begin
				r.jt = 1;
				r.jtarget = a;
				v = pc + LINK_OFFSET;
				wr = 1;
				rd = LINK_REG;
			end
			default: ;
		endcase
		if (wr) begin
			r.we = 1;
			r.wreg = rd;
			r.wval = v;
		end
	endtask

	always @(posedge clk) begin
		res_t got, want, pred;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[0], m_axis_tdata[5:1], m_axis_tdata[37:6],
				m_axis_tdata[39:38], m_axis_tdata[40], m_axis_tdata[72:41]};
			if (result_q.size() == 0) begin
				$error("unexpected result transaction %h", got);
				errors++;
			end else begin
				want = result_q.pop_front();
				if (got.we !== want.we) begin
					$error("write_enable: expected %0d, got %0d", want.we, got.we);
					errors++;
				end
				if (got.wreg !== want.wreg) begin
					$error("write_reg: expected %0d, got %0d", want.wreg, got.wreg);
					errors++;
				end
				if (got.wval !== want.wval) begin
					$error("write_value: expected %h, got %h", want.wval, got.wval);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
				if (got.jt !== want.jt) begin
					$error("jump_taken: expected %0d, got %0d", want.jt, got.jt);
					errors++;
				end
				if (got.jtarget !== want.jtarget) begin
					$error("jump_target: expected %h, got %h", want.jtarget, got.jtarget);
					errors++;
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			execute_instr(s_axis_tdata, pred);
			result_q.push_back(row_typed ? row_res : pred);
			accepted++;
		end
	end

	// A requested hold keeps the receiver stalled for that many cycles.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_instr(input instr_row_t row);
		int unsigned seen;
		if ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, row.pc, row.sh, row.rd, row.b, row.a, row.op};
		row_typed <= row.typed;
		row_res <= row.res;
		seen = accepted;
		do @(negedge clk); while (accepted == seen);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(15);
			5: return -$urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_row_t mk(logic [4:0] op, logic [31:0] a, logic [31:0] b,
			logic [4:0] rd, logic [4:0] sh, logic [31:0] pc);
		instr_row_t row;
		row.op = op; row.a = a; row.b = b; row.rd = rd; row.sh = sh; row.pc = pc;
		row.typed = 0;
		row.res = '0;
		return row;
	endfunction

	function automatic instr_row_t mk_typed(instr_row_t row, logic we, logic [4:0] wreg,
			logic [31:0] wval, logic [1:0] status);
		row.typed = 1;
		row.res = '0;
		row.res.we = we;
		row.res.wreg = wreg;
		row.res.wval = wval;
		row.res.status = status;
		return row;
	endfunction

	instr_row_t directed[$];

	initial begin
		instr_row_t row;
		errors = 0;
		accepted = 0;
		hi_reg = '0;
		lo_reg = '0;
		gap_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		row_typed = 0;
		row_res = '0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;

		// HI/LO read back as zero right after reset.
		directed.push_back(mk_typed(mk(OP_MFHI, 0, 0, 5'd5, 0, 0), 1, 5'd5, 0, ST_OK));
		directed.push_back(mk_typed(mk(OP_MFLO, 0, 0, 5'd0, 0, 0), 1, 5'd0, 0, ST_OK));
		directed.push_back(mk_typed(mk(OP_ADD, 32'h7FFF_FFFF, 1, 3, 0, 0), 0, 0, 0, ST_OVF));
		directed.push_back(mk_typed(mk(OP_SUB, 32'h8000_0000, 1, 3, 0, 0), 0, 0, 0, ST_OVF));
		directed.push_back(mk_typed(mk(OP_DIV, 32'hFFFF_FFFF, 0, 7, 0, 0), 0, 0, 0, ST_DIVZ));
		directed.push_back(mk_typed(mk(OP_DIVU, 32'hFFFF_FFFF, 0, 7, 0, 0), 0, 0, 0, ST_DIVZ));
		directed.push_back(mk_typed(mk(5'd31, '1, '1, '1, '1, '1), 0, 0, 0, ST_OK));
		directed.push_back(mk_typed(mk(5'd25, '1, '1, '1, '1, '1), 0, 0, 0, ST_OK));
		directed.push_back(mk(OP_ADDU, '1, '1, 31, 31, '1));
		directed.push_back(mk(OP_SUBU, 0, 1, 1, 0, 0));
		directed.push_back(mk(OP_AND, 32'hF0F0_F0F0, '1, 2, 0, 0));
		directed.push_back(mk(OP_OR, 32'h0F0F_0F0F, 32'hF000_0000, 4, 0, 0));
		directed.push_back(mk(OP_XOR, '1, 32'h5555_5555, 8, 0, 0));
		directed.push_back(mk(OP_MULT, '1, 32'h8000_0000, 0, 0, 0));
		directed.push_back(mk(OP_MFHI, 0, 0, 9, 0, 0));
		directed.push_back(mk(OP_MULTU, '1, '1, 0, 0, 0));
		directed.push_back(mk(OP_MFHI, 0, 0, 10, 0, 0));
		directed.push_back(mk(OP_DIV, 32'h8000_0000, '1, 0, 0, 0));
		directed.push_back(mk(OP_MFLO, 0, 0, 11, 0, 0));
		directed.push_back(mk(OP_DIV, -32'd7, 2, 0, 0, 0));
		directed.push_back(mk(OP_MFHI, 0, 0, 12, 0, 0));
		directed.push_back(mk(OP_MTHI, 32'hDEAD_BEEF, 0, 0, 0, 0));
		directed.push_back(mk(OP_MTLO, 32'h1234_5678, 0, 0, 0, 0));
		directed.push_back(mk(OP_SLT, 32'h8000_0000, 1, 13, 0, 0));
		directed.push_back(mk(OP_SLTU, 32'h8000_0000, 1, 14, 0, 0));
		directed.push_back(mk(OP_SLL, 0, '1, 15, 31, 0));
		directed.push_back(mk(OP_SRAV, 32'hFFFF_FFE1, 32'h8000_0000, 16, 0, 0));
		directed.push_back(mk(OP_JALR, 32'hCAFE_0000, 0, 17, 0, 32'hFFFF_FFFC));
		directed.push_back(mk(OP_JR, '1, 0, 18, 0, 0));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) send_instr(directed[i]);
		s_axis_tvalid <= 1'b0;
		row_typed <= 1'b0;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 87; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 87; end
				default: begin gap_pct = 24; stall_pct = 24; end
			endcase
			// Long receiver hold so the queue fills and the input stalls.
			if (ph == 0) hold_cycles = 300;
			for (int n = 0; n < 270; n++) begin
				row = mk(5'($urandom_range(99) < 5 ? $urandom_range(31, 25)
						: $urandom_range(24)),
					pick_word(), pick_word(), 5'($urandom), 5'($urandom), $urandom);
				send_instr(row);
			end
			s_axis_tvalid <= 1'b0;
			// Pause the input until every pending result is out.
			while (result_q.size() != 0) @(negedge clk);
		end

		repeat (100) @(negedge clk);
		if (errors == 0 && result_q.size() == 0)
			$display("mips_r_type_execute_unit_core regression: pass");
		else
			$display("mips_r_type_execute_unit_core regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
